### sv/assert_macros.svh
// assertion macros used by the rtl file of the init sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen at a rising clock edge outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### sv/psmi_pkg.sv
// types, constants and command table of the ps/2 mouse init sequencer
package psmi_pkg;

    localparam int unsigned STEP_W = 5;
    localparam int unsigned POS_W  = 2;

    // request codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_RX    = 1'b1;

    // script steps
    localparam logic [STEP_W-1:0] STEP_IDLE       = 5'd0;
    localparam logic [STEP_W-1:0] STEP_FIRST      = 5'd1;
    localparam logic [STEP_W-1:0] STEP_RESET_LAST = 5'd3;
    localparam logic [STEP_W-1:0] STEP_ID         = 5'd10;
    localparam logic [STEP_W-1:0] STEP_LAST       = 5'd16;

    // reply positions
    localparam logic [POS_W-1:0] POS_FIRST  = 2'd0;
    localparam logic [POS_W-1:0] POS_SECOND = 2'd1;
    localparam logic [POS_W-1:0] POS_THIRD  = 2'd2;

    // mouse reply bytes
    localparam logic [7:0] BYTE_ACK     = 8'hFA;
    localparam logic [7:0] BYTE_BAT_OK  = 8'hAA;
    localparam logic [7:0] BYTE_ID_STD  = 8'h00;
    localparam logic [7:0] BYTE_ID_WHEEL = 8'h03;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } psmi_in_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       init_done;
        logic       wheel_present;
    } psmi_out_t;

    // command sent on completing step n; index 0 is the byte sent on start
    function automatic logic [7:0] next_cmd(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'hFF;
            4'd1:    b = 8'hFF;
            4'd2:    b = 8'hFF;
            4'd3:    b = 8'hF3;
            4'd4:    b = 8'hC8;
            4'd5:    b = 8'hF3;
            4'd6:    b = 8'h64;
            4'd7:    b = 8'hF3;
            4'd8:    b = 8'h50;
            4'd9:    b = 8'hF2;
            4'd10:   b = 8'hE8;
            4'd11:   b = 8'h03;
            4'd12:   b = 8'hE6;
            4'd13:   b = 8'hF3;
            4'd14:   b = 8'h28;
            4'd15:   b = 8'hF4;
            default: b = 8'hFF;
        endcase
        return b;
    endfunction

    // reply expected after a reset command, by position
    function automatic logic [7:0] reset_reply(input logic [POS_W-1:0] pos);
        logic [7:0] b;
        case (pos)
            POS_FIRST:  b = BYTE_ACK;
            POS_SECOND: b = BYTE_BAT_OK;
            default:    b = BYTE_ID_STD;
        endcase
        return b;
    endfunction

endpackage

### sv/ps2_mouse_init_sequencer.sv
// ps/2 mouse init sequencer: reply matching and command issue
//
//  channel | direction | payload                                        | handshake
//  in      | to block  | cmd, rx_byte                                   | in_valid / in_ready
//  out     | from block| tx_valid, tx_byte, init_done, wheel_present     | out_valid / out_ready
//
// one request per cycle sustained while out_ready holds; the result is offered once the
// input register and then the result register load, with matching in between
// rst_n clears the script to idle and both flags; payload registers are not reset
// a stalled result holds in the result register while one more request is taken
// into the input register; in_ready drops only when both registers are full
`include "assert_macros.svh"

module ps2_mouse_init_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  psmi_pkg::psmi_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output psmi_pkg::psmi_out_t out_data
);

    logic                        in_valid_reg;
    psmi_pkg::psmi_in_t          in_data_reg;
    logic                        out_valid_reg;
    psmi_pkg::psmi_out_t         out_data_reg;
    psmi_pkg::psmi_out_t         out_data_next;

    logic [psmi_pkg::STEP_W-1:0] step_reg;
    logic [psmi_pkg::STEP_W-1:0] step_next;
    logic [psmi_pkg::POS_W-1:0]  pos_reg;
    logic [psmi_pkg::POS_W-1:0]  pos_next;
    logic                        done_reg;
    logic                        done_next;
    logic                        wheel_reg;
    logic                        wheel_next;

    logic                        advance;
    logic                        step_active;
    logic                        match_part;
    logic                        match_full;
    logic [7:0]                  rx;

    logic                        pos_legal;
    logic                        start_taken;
    logic                        start_issued;
    logic                        out_idle;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign rx          = in_data_reg.rx_byte;
    assign step_active = (step_reg >= psmi_pkg::STEP_FIRST)
                      && (step_reg <= psmi_pkg::STEP_LAST);

    // classify the received byte against the reply the current step waits for
    always_comb
    begin
        match_part = 1'b0;
        match_full = 1'b0;
        if (step_reg <= psmi_pkg::STEP_RESET_LAST)
        begin
            if (pos_reg <= psmi_pkg::POS_THIRD && rx == psmi_pkg::reset_reply(pos_reg))
            begin
                match_full = (pos_reg == psmi_pkg::POS_THIRD);
                match_part = (pos_reg != psmi_pkg::POS_THIRD);
            end
        end
        else if (step_reg == psmi_pkg::STEP_ID)
        begin
            if (pos_reg == psmi_pkg::POS_FIRST)
                match_part = (rx == psmi_pkg::BYTE_ACK);
            else if (pos_reg == psmi_pkg::POS_SECOND)
                match_full = (rx == psmi_pkg::BYTE_ID_STD)
                          || (rx == psmi_pkg::BYTE_ID_WHEEL);
        end
        else
        begin
            match_full = (pos_reg == psmi_pkg::POS_FIRST) && (rx == psmi_pkg::BYTE_ACK);
        end
    end

    always_comb
    begin
        step_next  = step_reg;
        pos_next   = pos_reg;
        done_next  = done_reg;
        wheel_next = wheel_reg;
        out_data_next.tx_valid = 1'b0;
        out_data_next.tx_byte  = 8'h00;
        if (advance)
        begin
            if (in_data_reg.cmd == psmi_pkg::CMD_START)
            begin
                out_data_next.tx_valid = 1'b1;
                out_data_next.tx_byte  = psmi_pkg::next_cmd(4'd0);
                step_next = psmi_pkg::STEP_FIRST;
                pos_next  = psmi_pkg::POS_FIRST;
            end
            else if (step_active)
            begin
                if (match_part)
                begin
                    pos_next = pos_reg + 2'd1;
                end
                else if (match_full)
                begin
                    pos_next = psmi_pkg::POS_FIRST;
                    if (step_reg == psmi_pkg::STEP_ID)
                        wheel_next = (rx == psmi_pkg::BYTE_ID_WHEEL);
                    if (step_reg == psmi_pkg::STEP_LAST)
                    begin
                        done_next = 1'b1;
                        step_next = psmi_pkg::STEP_IDLE;
                    end
                    else
                    begin
                        out_data_next.tx_valid = 1'b1;
                        out_data_next.tx_byte  = psmi_pkg::next_cmd(step_reg[3:0]);
                        step_next = step_reg + 5'd1;
                    end
                end
                else
                begin
                    // mismatch drops the partial reply and the byte itself
                    pos_next = psmi_pkg::POS_FIRST;
                end
            end
        end
        out_data_next.init_done     = done_next;
        out_data_next.wheel_present = wheel_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= psmi_pkg::STEP_IDLE;
            pos_reg       <= psmi_pkg::POS_FIRST;
            done_reg      <= 1'b0;
            wheel_reg     <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            step_reg  <= step_next;
            pos_reg   <= pos_next;
            done_reg  <= done_next;
            wheel_reg <= wheel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_data_reg <= in_data;
        if (advance)
            out_data_reg <= out_data_next;
    end

    // reply position allowed for the current step
    assign pos_legal = (pos_reg == psmi_pkg::POS_FIRST)
                    || ((step_reg >= psmi_pkg::STEP_FIRST)
                        && (step_reg <= psmi_pkg::STEP_RESET_LAST)
                        && (pos_reg <= psmi_pkg::POS_THIRD))
                    || ((step_reg == psmi_pkg::STEP_ID) && (pos_reg == psmi_pkg::POS_SECOND));
    assign start_taken  = advance && (in_data_reg.cmd == psmi_pkg::CMD_START);
    assign start_issued = (step_reg == psmi_pkg::STEP_FIRST) && out_valid_reg
                       && out_data_reg.tx_valid;
    assign out_idle     = out_valid_reg && !out_data_reg.tx_valid;

    `ASSERT_NEVER(a_step_range, step_reg > psmi_pkg::STEP_LAST, "script step beyond last step")
    `ASSERT_CLK(a_pos_legal, pos_legal, "reply position illegal for step")
    `ASSERT_CLK(a_done_sticky, done_reg |=> done_reg, "init done flag cleared")
    `ASSERT_CLK(a_start_issues_reset, start_taken |=> start_issued, "start did not issue reset")
    `ASSERT_CLK(a_idle_byte_zero, out_idle |-> (out_data_reg.tx_byte == 8'h00), "stray tx byte")

endmodule
